// ===== rtl/hrp_pkg.sv =====
// shared types, constants and prefix table of the http request header parser
package hrp_pkg;

  // message and field sizes
  localparam int MSG_BYTES = 4096;
  localparam int POS_W     = 13;
  localparam int START_W   = 12;
  localparam int LEN_W     = 13;
  localparam int VALUE_W   = 32;
  localparam int KIND_W    = 4;
  localparam int VT_W      = 8;
  localparam int COL_W     = 5;

  // result queue between parser and output stage
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // header prefixes
  localparam int NUM_PREFIX  = 6;
  localparam int PREFIX_MAX  = 18;
  localparam int PREFIX_BITS = PREFIX_MAX * 8;

  // byte codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // header codes
  localparam logic [2:0] HDR_CLEN = 3'd2;
  localparam logic [2:0] HDR_NONE = 3'd7;

  // saturation limits
  localparam logic [31:0] CLAMP_MAG = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
  localparam logic [VT_W-1:0] VT_MAX = 8'd255;

  typedef enum logic [2:0] {
    PH_METHOD = 3'd0,
    PH_URL    = 3'd1,
    PH_PROTO  = 3'd2,
    PH_VER    = 3'd3,
    PH_LINE   = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    NS_LEAD = 2'd0,
    NS_INT  = 2'd1,
    NS_FRAC = 2'd2,
    NS_STOP = 2'd3
  } num_stage_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_METHOD  = 4'd0,
    KIND_URL     = 4'd1,
    KIND_VERSION = 4'd2,
    KIND_HOST    = 4'd3,
    KIND_AGENT   = 4'd4,
    KIND_CLEN    = 4'd5,
    KIND_CTYPE   = 4'd6,
    KIND_CENC    = 4'd7,
    KIND_CONN    = 4'd8,
    KIND_OK      = 4'd9,
    KIND_ERROR   = 4'd10
  } kind_e;

  // one token result
  typedef struct packed {
    kind_e               kind;
    logic [START_W-1:0]  start;
    logic [LEN_W-1:0]    length;
    logic [VALUE_W-1:0]  value;
  } hrp_result_t;

  // results caused by one byte: an optional token and an optional status
  typedef struct packed {
    logic        tok_vld;
    hrp_result_t tok;
    logic        stat_vld;
    logic        stat_ok;
  } hrp_entry_t;

  // number parser state
  typedef struct packed {
    logic [31:0]     acc;
    logic            sign;
    logic [VT_W-1:0] vt;
    num_stage_e      stage;
  } num_t;

  localparam num_t NUM_CLEAR = '{acc: 32'd0, sign: 1'b0, vt: '0, stage: NS_LEAD};

  localparam logic [PREFIX_BITS-1:0] PREFIX_TEXT [NUM_PREFIX] = '{
    "Host: ", "User-Agent: ", "Content-Length: ",
    "Content-Type: ", "Content-Encoding: ", "Connection: "
  };
  localparam logic [COL_W-1:0] PREFIX_LEN [NUM_PREFIX] = '{
    5'd6, 5'd12, 5'd16, 5'd14, 5'd18, 5'd12
  };

  // character of a prefix at a column, zero past its end
  function automatic logic [7:0] prefix_char(input logic [2:0] idx,
                                             input logic [COL_W-1:0] col);
    logic [PREFIX_BITS-1:0] txt;
    logic [COL_W-1:0]       len;
    logic [COL_W-1:0]       sh;
    logic [7:0]             ch;
    txt = '0;
    len = '0;
    ch  = CH_NUL;
    if (idx < 3'(NUM_PREFIX)) begin
      txt = PREFIX_TEXT[idx];
      len = PREFIX_LEN[idx];
    end
    sh = len - 5'd1 - col;
    if (col < len) begin
      ch = txt[{sh, 3'b000} +: 8];
    end
    return ch;
  endfunction

endpackage

// ===== rtl/hrp_front.sv =====
// parser front: takes message bytes, tracks the request state, builds result entries
module hrp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  input  logic                q_full_i,
  output logic                push_o,
  output hrp_pkg::hrp_entry_t entry_o
);

  hrp_pkg::phase_e            phase_q, phase_d;
  logic [hrp_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [hrp_pkg::START_W-1:0] start_q, start_d;
  logic [hrp_pkg::NUM_PREFIX-1:0] cand_q, cand_d;
  logic [hrp_pkg::COL_W-1:0]   col_q, col_d;
  hrp_pkg::num_t               num_q, num_d;
  logic [2:0]                  hdr_q, hdr_d;
  logic                        in_tok_q, in_tok_d;
  logic                        seen_q, seen_d;

  logic accept;

  // one decimal digit into the accumulator or the version
  function automatic hrp_pkg::num_t num_digit(input hrp_pkg::num_t n, input logic [3:0] d,
                                              input logic ver);
    hrp_pkg::num_t r;
    logic [11:0]   t;
    logic [35:0]   a;
    r = n;
    t = 12'(n.vt) * 12'd10 + 12'(d) * 12'd10;
    a = 36'(n.acc) * 36'd10 + 36'(d);
    if (ver) begin
      r.vt = (t > 12'(hrp_pkg::VT_MAX)) ? hrp_pkg::VT_MAX : t[hrp_pkg::VT_W-1:0];
    end else begin
      r.acc = (a > 36'(hrp_pkg::CLAMP_MAG)) ? hrp_pkg::CLAMP_MAG : a[31:0];
    end
    return r;
  endfunction

  // one byte into the number parser
  function automatic hrp_pkg::num_t num_feed(input hrp_pkg::num_t n, input logic [7:0] b,
                                             input logic ver);
    hrp_pkg::num_t r;
    logic          digit;
    logic [3:0]    d;
    logic [8:0]    t;
    r     = n;
    digit = (b >= hrp_pkg::CH_ZERO) && (b <= hrp_pkg::CH_NINE);
    d     = 4'(b - hrp_pkg::CH_ZERO);
    t     = 9'(n.vt) + 9'(d);
    case (n.stage)
      hrp_pkg::NS_LEAD: begin
        if (b == hrp_pkg::CH_SPACE || b == hrp_pkg::CH_TAB ||
            b == hrp_pkg::CH_VT || b == hrp_pkg::CH_FF) begin
          r = n;
        end else if (b == hrp_pkg::CH_PLUS || b == hrp_pkg::CH_MINUS) begin
          r.sign  = (b == hrp_pkg::CH_MINUS);
          r.stage = hrp_pkg::NS_INT;
        end else if (b == hrp_pkg::CH_DOT && ver) begin
          r.stage = hrp_pkg::NS_FRAC;
        end else if (digit) begin
          r       = num_digit(n, d, ver);
          r.stage = hrp_pkg::NS_INT;
        end else begin
          r.stage = hrp_pkg::NS_STOP;
        end
      end
      hrp_pkg::NS_INT: begin
        if (digit) begin
          r = num_digit(n, d, ver);
        end else if (b == hrp_pkg::CH_DOT && ver) begin
          r.stage = hrp_pkg::NS_FRAC;
        end else begin
          r.stage = hrp_pkg::NS_STOP;
        end
      end
      hrp_pkg::NS_FRAC: begin
        if (digit) begin
          r.vt = (t > 9'(hrp_pkg::VT_MAX)) ? hrp_pkg::VT_MAX : t[hrp_pkg::VT_W-1:0];
        end
        r.stage = hrp_pkg::NS_STOP;
      end
      default: r = n;
    endcase
    return r;
  endfunction

  // whether closing a token in this phase gives a result
  function automatic logic close_emit(input hrp_pkg::phase_e ph, input logic [2:0] hdr);
    return (ph == hrp_pkg::PH_METHOD) || (ph == hrp_pkg::PH_URL) ||
           (ph == hrp_pkg::PH_VER) || (ph == hrp_pkg::PH_LINE && hdr != hrp_pkg::HDR_NONE);
  endfunction

  // result of closing a token that ends at a position
  function automatic hrp_pkg::hrp_result_t close_tok(
    input hrp_pkg::phase_e             ph,
    input logic [hrp_pkg::START_W-1:0] st,
    input logic [hrp_pkg::POS_W-1:0]   e,
    input logic [2:0]                  hdr,
    input hrp_pkg::num_t               n
  );
    hrp_pkg::hrp_result_t r;
    logic [31:0]          vt32;
    r.start  = st;
    r.length = e - {1'b0, st};
    r.value  = '0;
    vt32     = 32'(n.vt);
    case (ph)
      hrp_pkg::PH_METHOD: r.kind = hrp_pkg::KIND_METHOD;
      hrp_pkg::PH_URL:    r.kind = hrp_pkg::KIND_URL;
      hrp_pkg::PH_VER: begin
        r.kind  = hrp_pkg::KIND_VERSION;
        r.value = n.sign ? (32'd0 - vt32) : vt32;
      end
      default: begin
        r.kind = hrp_pkg::kind_e'(4'(hrp_pkg::KIND_HOST) + {1'b0, hdr});
        if (hdr == hrp_pkg::HDR_CLEN) begin
          if (n.sign) begin
            r.value = 32'd0 - n.acc;
          end else begin
            r.value = (n.acc > hrp_pkg::POS_MAX) ? hrp_pkg::POS_MAX : n.acc;
          end
        end
      end
    endcase
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // next state and results of one byte
  always_comb begin
    logic crlf;
    phase_d  = phase_q;
    pos_d    = pos_q;
    start_d  = start_q;
    cand_d   = cand_q;
    col_d    = col_q;
    num_d    = num_q;
    hdr_d    = hdr_q;
    in_tok_d = in_tok_q;
    seen_d   = seen_q;
    entry_o  = '0;
    crlf     = (in_byte_i == hrp_pkg::CH_CR) || (in_byte_i == hrp_pkg::CH_LF);
    if (accept) begin
      if (phase_q != hrp_pkg::PH_DONE) begin
        if (in_byte_i == hrp_pkg::CH_NUL ||
            pos_q >= hrp_pkg::POS_W'(hrp_pkg::MSG_BYTES - 1)) begin
          // end of string: close any open token and ignore the rest
          if (in_tok_q) begin
            entry_o.tok     = close_tok(phase_q, start_q, pos_q, hdr_q, num_q);
            entry_o.tok_vld = close_emit(phase_q, hdr_q);
          end
          in_tok_d = 1'b0;
          phase_d  = hrp_pkg::PH_DONE;
        end else begin
          pos_d = pos_q + 13'd1;
          case (phase_q)
            // method and url: space separated tokens
            hrp_pkg::PH_METHOD, hrp_pkg::PH_URL: begin
              if (in_tok_q) begin
                if (in_byte_i == hrp_pkg::CH_SPACE) begin
                  entry_o.tok     = close_tok(phase_q, start_q, pos_q, hdr_q, num_q);
                  entry_o.tok_vld = 1'b1;
                  in_tok_d        = 1'b0;
                  phase_d = (phase_q == hrp_pkg::PH_METHOD) ? hrp_pkg::PH_URL
                                                            : hrp_pkg::PH_PROTO;
                end
              end else if (in_byte_i != hrp_pkg::CH_SPACE) begin
                in_tok_d = 1'b1;
                start_d  = pos_q[hrp_pkg::START_W-1:0];
              end
            end
            // protocol name up to the slash
            hrp_pkg::PH_PROTO: begin
              if (in_tok_q) begin
                if (in_byte_i == hrp_pkg::CH_SLASH) begin
                  in_tok_d = 1'b0;
                  phase_d  = hrp_pkg::PH_VER;
                end
              end else if (in_byte_i != hrp_pkg::CH_SLASH) begin
                in_tok_d = 1'b1;
                start_d  = pos_q[hrp_pkg::START_W-1:0];
              end
            end
            // version up to the line end
            hrp_pkg::PH_VER: begin
              if (in_tok_q) begin
                if (crlf) begin
                  entry_o.tok     = close_tok(phase_q, start_q, pos_q, hdr_q, num_q);
                  entry_o.tok_vld = 1'b1;
                  in_tok_d        = 1'b0;
                  phase_d         = hrp_pkg::PH_LINE;
                end else begin
                  num_d = num_feed(num_q, in_byte_i, 1'b1);
                end
              end else if (!crlf) begin
                in_tok_d = 1'b1;
                start_d  = pos_q[hrp_pkg::START_W-1:0];
                seen_d   = 1'b1;
                num_d    = num_feed(hrp_pkg::NUM_CLEAR, in_byte_i, 1'b1);
              end
            end
            // header and body lines
            default: begin
              if (in_tok_q && crlf) begin
                entry_o.tok     = close_tok(phase_q, start_q, pos_q, hdr_q, num_q);
                entry_o.tok_vld = close_emit(phase_q, hdr_q);
                in_tok_d        = 1'b0;
              end else if (!crlf) begin
                if (!in_tok_q) begin
                  in_tok_d = 1'b1;
                  col_d    = '0;
                  cand_d   = '1;
                  hdr_d    = hrp_pkg::HDR_NONE;
                end
                if (hdr_d != hrp_pkg::HDR_NONE) begin
                  if (hdr_d == hrp_pkg::HDR_CLEN) begin
                    num_d = num_feed(num_q, in_byte_i, 1'b0);
                  end
                end else if (cand_d != '0) begin
                  // drop prefixes that differ at this column
                  for (int i = 0; i < hrp_pkg::NUM_PREFIX; i++) begin
                    if (cand_d[i] && hrp_pkg::prefix_char(3'(i), col_d) != in_byte_i) begin
                      cand_d[i] = 1'b0;
                    end
                  end
                  col_d = col_d + 5'd1;
                  // a prefix that ends here starts the header value
                  for (int i = 0; i < hrp_pkg::NUM_PREFIX; i++) begin
                    if (cand_d[i] && hrp_pkg::PREFIX_LEN[i] == col_d) begin
                      hdr_d   = 3'(i);
                      start_d = hrp_pkg::START_W'(pos_q + 13'd1);
                      num_d   = hrp_pkg::NUM_CLEAR;
                    end
                  end
                end
              end
            end
          endcase
        end
      end
      if (in_last_i) begin
        // end of message: open token, then status, then back to reset
        if (phase_d != hrp_pkg::PH_DONE && in_tok_d) begin
          entry_o.tok     = close_tok(phase_d, start_d, pos_d, hdr_d, num_d);
          entry_o.tok_vld = close_emit(phase_d, hdr_d);
        end
        entry_o.stat_vld = 1'b1;
        entry_o.stat_ok  = seen_d;
        phase_d  = hrp_pkg::PH_METHOD;
        pos_d    = '0;
        start_d  = '0;
        cand_d   = '1;
        col_d    = '0;
        num_d    = hrp_pkg::NUM_CLEAR;
        hdr_d    = hrp_pkg::HDR_NONE;
        in_tok_d = 1'b0;
        seen_d   = 1'b0;
      end
    end
  end

  assign push_o = accept && (entry_o.tok_vld || entry_o.stat_vld);

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= hrp_pkg::PH_METHOD;
      pos_q    <= '0;
      start_q  <= '0;
      cand_q   <= '1;
      col_q    <= '0;
      num_q    <= hrp_pkg::NUM_CLEAR;
      hdr_q    <= hrp_pkg::HDR_NONE;
      in_tok_q <= 1'b0;
      seen_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      cand_q   <= cand_d;
      col_q    <= col_d;
      num_q    <= num_d;
      hdr_q    <= hdr_d;
      in_tok_q <= in_tok_d;
      seen_q   <= seen_d;
    end
  end

endmodule

// ===== rtl/hrp_fifo.sv =====
// short queue of result entries between parser and output stage
module hrp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hrp_pkg::hrp_entry_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output hrp_pkg::hrp_entry_t pop_data_o,
  output logic                empty_o
);

  hrp_pkg::hrp_entry_t                  mem_q [hrp_pkg::FIFO_DEPTH];
  logic [hrp_pkg::FIFO_PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [hrp_pkg::FIFO_CNT_W-1:0]       cnt_q;
  logic                                 do_push, do_pop;

  assign full_o     = (cnt_q == hrp_pkg::FIFO_CNT_W'(hrp_pkg::FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/hrp_back.sv =====
// output stage: plays each queued entry out as one or two result transfers
module hrp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hrp_pkg::hrp_entry_t entry_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hrp_pkg::hrp_result_t out_res_o,
  output logic                out_last_o
);

  logic                 tok_pend_q, stat_pend_q;
  hrp_pkg::hrp_result_t tok_q;
  logic                 ok_q;
  logic                 xfer, done;

  assign out_valid_o = tok_pend_q || stat_pend_q;
  assign xfer        = out_valid_o && out_ready_i;
  // register free after this cycle
  assign done        = !out_valid_o || (xfer && !(tok_pend_q && stat_pend_q));
  assign pop_o       = done && !empty_i;

  // token first, status after it
  always_comb begin
    out_res_o  = tok_q;
    out_last_o = 1'b0;
    if (!tok_pend_q) begin
      out_res_o.kind   = ok_q ? hrp_pkg::KIND_OK : hrp_pkg::KIND_ERROR;
      out_res_o.start  = '0;
      out_res_o.length = '0;
      out_res_o.value  = '0;
      out_last_o       = 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tok_q <= entry_i.tok;
      ok_q  <= entry_i.stat_ok;
    end
  end

  // pending flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_pend_q  <= 1'b0;
      stat_pend_q <= 1'b0;
    end else if (pop_o) begin
      tok_pend_q  <= entry_i.tok_vld;
      stat_pend_q <= entry_i.stat_vld;
    end else if (xfer) begin
      if (tok_pend_q) begin
        tok_pend_q <= 1'b0;
      end else begin
        stat_pend_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/http_request_header_parser_unit.sv =====
// top level of the http request header parser: parser, result queue, output stage
//
// channel  dir  tdata                                   tuser       tlast
// s_axis   in   [7:0] msg_byte                          -           msg_last
// m_axis   out  [11:0] field_start, [24:12]             [3:0]       result_last
//               field_length, [56:25] field_value       field_kind
//
// one byte is taken every cycle while the four-entry result queue has room
// a byte that closes a token on the last byte gives two results and holds the
// output for two transfers; results pass through the queue and the output register
// the parse state and the queue pointers clear at once on reset, no sweep
// an output stall backs up through the queue to s_axis_tready_o
module http_request_header_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] msg_byte
  input  logic        s_axis_tlast_i,   // msg_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [11:0] start, [24:12] length, [56:25] value
  output logic [3:0]  m_axis_tuser_o,   // [3:0] field_kind
  output logic        m_axis_tlast_o    // result_last
);

  logic                 q_full, q_empty, push, pop;
  hrp_pkg::hrp_entry_t  push_entry, pop_entry;
  hrp_pkg::hrp_result_t out_res;

  hrp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  hrp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .empty_o     (q_empty)
  );

  hrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (pop_entry),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res),
    .out_last_o  (m_axis_tlast_o)
  );

  // pack the result fields
  assign m_axis_tdata_o = {7'd0, out_res.value, out_res.length, out_res.start};
  assign m_axis_tuser_o = out_res.kind;

endmodule

// ===== tb/sv/http_request_header_parser_unit_tb.sv =====
// self-checking testbench for the http request header parser unit
`timescale 1ns / 100ps

module http_request_header_parser_unit_tb;
  import hrp_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  // random share of the run, directed and full-rate traffic make up the rest
  localparam int RANDOM_BYTES = 600;

  // one result of the parser as seen on m_axis
  typedef struct {
    kind_e        kind;
    logic [11:0]  start;
    logic [12:0]  length;
    logic [31:0]  value;
    logic         last;
  } field_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b1;
  logic [63:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  field_t      expected_fields[$];
  logic [7:0]  msg_q[$];
  int          errors = 0;
  int          sent_bytes = 0;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;

  string hdr_prefix[6] = '{"Host: ", "User-Agent: ", "Content-Length: ",
                           "Content-Type: ", "Content-Encoding: ", "Connection: "};

  // parser state mirrored by the prediction
  phase_e      ph;
  int unsigned pos_q;
  int unsigned tok_start;
  logic [5:0]  live;
  int unsigned col;
  logic [31:0] acc;
  logic        neg;
  int unsigned tenths;
  num_stage_e  nstage;
  logic [2:0]  hdr;
  bit          in_tok;
  bit          ver_seen;

  http_request_header_parser_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic void number_clear();
    acc    = '0;
    neg    = 1'b0;
    tenths = 0;
    nstage = NS_LEAD;
  endfunction

  function automatic void parser_clear();
    ph        = PH_METHOD;
    pos_q     = 0;
    tok_start = 0;
    live      = '1;
    col       = 0;
    hdr       = HDR_NONE;
    in_tok    = 1'b0;
    ver_seen  = 1'b0;
    number_clear();
  endfunction

  function automatic void emit_field(kind_e k, int unsigned s, int unsigned n,
                                     logic [31:0] v, logic l);
    field_t f;
    f.kind   = k;
    f.start  = s[11:0];
    f.length = n[12:0];
    f.value  = v;
    f.last   = l;
    expected_fields.push_back(f);
  endfunction

  // version digits count in tenths, saturating at 255; other digits go into acc, clamped at CLAMP_MAG
  function automatic void add_digit(int unsigned d, bit ver);
    int unsigned t;
    logic [63:0] wide;
    if (ver) begin
      t = tenths * 10 + d * 10;
      tenths = (t > 255) ? 255 : t;
    end else begin
      wide = 64'(acc) * 10 + 64'(d);
      acc = (wide > 64'(CLAMP_MAG)) ? CLAMP_MAG : wide[31:0];
    end
  endfunction

  function automatic void number_feed(logic [7:0] b, bit ver);
    bit          is_digit;
    int unsigned t;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    case (nstage)
      NS_LEAD: begin
        if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF) return;
        if (b == CH_PLUS || b == CH_MINUS) begin
          neg    = (b == CH_MINUS);
          nstage = NS_INT;
        end else if (b == CH_DOT && ver) begin
          nstage = NS_FRAC;
        end else if (is_digit) begin
          nstage = NS_INT;
          add_digit(b - CH_ZERO, ver);
        end else begin
          nstage = NS_STOP;
        end
      end
      NS_INT: begin
        if (is_digit) add_digit(b - CH_ZERO, ver);
        else if (b == CH_DOT && ver) nstage = NS_FRAC;
        else nstage = NS_STOP;
      end
      NS_FRAC: begin
        if (is_digit) begin
          t = tenths + (b - CH_ZERO);
          tenths = (t > 255) ? 255 : t;
        end
        nstage = NS_STOP;
      end
      default: ;
    endcase
  endfunction

  function automatic void close_token(int unsigned stop);
    int unsigned len;
    logic [31:0] v;
    len    = stop - tok_start;
    in_tok = 1'b0;
    v      = '0;
    if (ph == PH_METHOD) begin
      emit_field(KIND_METHOD, tok_start, len, v, 1'b0);
    end else if (ph == PH_URL) begin
      emit_field(KIND_URL, tok_start, len, v, 1'b0);
    end else if (ph == PH_VER) begin
      v = neg ? (32'd0 - tenths) : tenths;
      emit_field(KIND_VERSION, tok_start, len, v, 1'b0);
    end else if (ph == PH_LINE && hdr < 3'd6) begin
      if (hdr == HDR_CLEN) v = neg ? (32'd0 - acc) : ((acc > POS_MAX) ? POS_MAX : acc);
      emit_field(kind_e'(KIND_HOST + hdr), tok_start, len, v, 1'b0);
    end
  endfunction

  // prefix match of a later line, then number parse of a content length
  function automatic void header_char(logic [7:0] b, int unsigned p);
    if (hdr != HDR_NONE) begin
      if (hdr == HDR_CLEN) number_feed(b, 1'b0);
      return;
    end
    if (live == '0) return;
    for (int i = 0; i < 6; i++)
      if (live[i] && hdr_prefix[i][col] != b) live[i] = 1'b0;
    col++;
    for (int i = 0; i < 6; i++)
      if (live[i] && hdr_prefix[i].len() == col) begin
        hdr       = 3'(i);
        tok_start = p + 1;
        number_clear();
      end
  endfunction

  function automatic void parse_byte(logic [7:0] b, int unsigned p);
    bit crlf;
    crlf = (b == CH_CR) || (b == CH_LF);
    case (ph)
      PH_METHOD, PH_URL: begin
        if (in_tok) begin
          if (b == CH_SPACE) begin
            close_token(p);
            ph = (ph == PH_METHOD) ? PH_URL : PH_PROTO;
          end
        end else if (b != CH_SPACE) begin
          in_tok    = 1'b1;
          tok_start = p;
        end
      end
      PH_PROTO: begin
        if (in_tok) begin
          if (b == CH_SLASH) begin
            in_tok = 1'b0;
            ph     = PH_VER;
          end
        end else if (b != CH_SLASH) begin
          in_tok    = 1'b1;
          tok_start = p;
        end
      end
      PH_VER: begin
        if (in_tok) begin
          if (crlf) begin
            close_token(p);
            ph = PH_LINE;
          end else begin
            number_feed(b, 1'b1);
          end
        end else if (!crlf) begin
          in_tok    = 1'b1;
          tok_start = p;
          ver_seen  = 1'b1;
          number_clear();
          number_feed(b, 1'b1);
        end
      end
      default: begin
        if (in_tok) begin
          if (crlf) close_token(p);
          else header_char(b, p);
        end else if (!crlf) begin
          in_tok = 1'b1;
          col    = 0;
          live   = '1;
          hdr    = HDR_NONE;
          header_char(b, p);
        end
      end
    endcase
  endfunction

  // expected results of one accepted byte
  function automatic void predict_byte(logic [7:0] b, logic last);
    if (ph != PH_DONE) begin
      if (b == CH_NUL || pos_q >= MSG_BYTES - 1) begin
        if (in_tok) close_token(pos_q);
        ph = PH_DONE;
      end else begin
        parse_byte(b, pos_q);
        pos_q++;
      end
    end
    if (last) begin
      if (ph != PH_DONE && in_tok) close_token(pos_q);
      emit_field(ver_seen ? KIND_OK : KIND_ERROR, 0, 0, '0, 1'b1);
      parser_clear();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : result_check
    field_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_fields.size() == 0) begin
        $error("unexpected result transfer, field_kind %0d", m_axis_tuser_o);
        errors++;
      end else begin
        want = expected_fields.pop_front();
        if (m_axis_tuser_o !== want.kind) begin
          $error("field_kind: expected %0d, got %0d", want.kind, m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tdata_o[11:0] !== want.start) begin
          $error("field_start: expected %0d, got %0d", want.start, m_axis_tdata_o[11:0]);
          errors++;
        end
        if (m_axis_tdata_o[24:12] !== want.length) begin
          $error("field_length: expected %0d, got %0d", want.length,
                 m_axis_tdata_o[24:12]);
          errors++;
        end
        if (m_axis_tdata_o[56:25] !== want.value) begin
          $error("field_value: expected %0d, got %0d", $signed(want.value),
                 $signed(m_axis_tdata_o[56:25]));
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("result_last: expected %0d, got %0d", want.last, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // receiver stalls in bursts
  always begin
    @(posedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      m_axis_tready_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      m_axis_tready_i <= 1'b1;
    end
  end

  // one byte transfer, with an occasional gap before it
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_byte(b, last);
    sent_bytes++;
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
    msg_q = {};
  endtask

  // hold the input until every pending result has been seen
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_fields.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // message building
  // ---------------------------------------------------------------------------

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endfunction

  function automatic void add_crlf();
    msg_q.push_back(CH_CR);
    msg_q.push_back(CH_LF);
  endfunction

  function automatic void rand_text(int n, int lo, int hi);
    repeat (n) msg_q.push_back(8'($urandom_range(hi, lo)));
  endfunction

  function automatic void add_eol();
    case ($urandom_range(0, 3))
      0: msg_q.push_back(CH_LF);
      1: msg_q.push_back(CH_CR);
      2: begin
        add_crlf();
        add_crlf();
      end
      default: add_crlf();
    endcase
  endfunction

  // decimal text with optional blanks, sign, fraction and trailing junk
  function automatic void add_number(bit ver);
    logic [7:0] blanks[4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
    string      big[4] = '{"2147483647", "2147483648", "4294967295", "99999999999"};
    repeat ($urandom_range(0, 2)) msg_q.push_back(blanks[$urandom_range(0, 3)]);
    case ($urandom_range(0, 3))
      1: msg_q.push_back(CH_PLUS);
      2: msg_q.push_back(CH_MINUS);
      default: ;
    endcase
    if (!ver && $urandom_range(0, 4) == 0) add_str(big[$urandom_range(0, 3)]);
    else rand_text($urandom_range(0, ver ? 3 : 11), CH_ZERO, CH_NINE);
    if (ver && $urandom_range(0, 1) == 1) begin
      msg_q.push_back(CH_DOT);
      rand_text($urandom_range(0, 2), CH_ZERO, CH_NINE);
    end
    if ($urandom_range(0, 5) == 0) rand_text(1, 8'h21, 8'h7E);
  endfunction

  // request-shaped message with random content
  function automatic void build_request();
    string methods[5] = '{"GET", "POST", "PUT", "HEAD", "DELETE"};
    int    k;
    string p;
    msg_q = {};
    if ($urandom_range(0, 5) == 0) rand_text($urandom_range(1, 2), CH_SPACE, CH_SPACE);
    if ($urandom_range(0, 3) == 0) rand_text($urandom_range(1, 7), 8'h41, 8'h5A);
    else add_str(methods[$urandom_range(0, 4)]);
    rand_text($urandom_range(1, 3), CH_SPACE, CH_SPACE);
    msg_q.push_back(CH_SLASH);
    rand_text($urandom_range(0, 10), 8'h21, 8'h7E);
    rand_text($urandom_range(1, 3), CH_SPACE, CH_SPACE);
    if ($urandom_range(0, 7) == 0) add_str("HTTP//");
    else add_str("HTTP/");
    case ($urandom_range(0, 4))
      0: add_str("1.1");
      1: add_str("1.0");
      2: add_str("2");
      default: add_number(1'b1);
    endcase
    add_eol();
    repeat ($urandom_range(0, 6)) begin
      k = $urandom_range(0, 8);
      if (k < 6) begin
        add_str(hdr_prefix[k]);
        if (k == 2) add_number(1'b0);
        else rand_text($urandom_range(0, 12), CH_SPACE, 8'h7E);
      end else if (k == 6) begin
        // wrong case never matches
        add_str(hdr_prefix[$urandom_range(0, 5)].tolower());
        rand_text($urandom_range(0, 6), CH_SPACE, 8'h7E);
      end else if (k == 7) begin
        // partial prefix keeps its candidates alive then breaks off
        p = hdr_prefix[$urandom_range(0, 5)];
        add_str(p.substr(0, $urandom_range(0, p.len() - 2)));
        rand_text($urandom_range(0, 4), 8'h21, 8'h7E);
      end else begin
        rand_text($urandom_range(1, 20), 8'h21, 8'h7E);
      end
      add_eol();
    end
    if ($urandom_range(0, 3) == 0) rand_text($urandom_range(1, 16), CH_SPACE, 8'h7E);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    string clen_vals[6] = '{" 99999999999", " -2147483648", " \t+2147483647x",
                            " -99999999999", " abc", "7"};
    string versions[6] = '{".5", "999", "+1.", "1.99", "-", "1.2.3"};
    // plain request with host and content length, ends on the blank line
    add_str("GET /index.html HTTP/1.1");
    add_crlf();
    add_str("Host: example.org");
    add_crlf();
    add_str("Content-Length: 42");
    add_crlf();
    add_crlf();
    send_msg();
    // collapsed spaces and slashes, every other header, last byte inside a value
    add_str("  PUT   /u   HTTP//-2.57\n\nUser-Agent: a b\nhost: no\nContent-Type: \n");
    add_str("Content-Encoding: gz\nHost: x\nHost: y\nConnection: close");
    send_msg();
    // no version token
    add_str("HEAD /");
    send_msg();
    // one-byte messages
    msg_q.push_back(8'hFF);
    send_msg();
    msg_q.push_back(CH_NUL);
    send_msg();
    // end of string in the middle of the request line
    add_str("GET /a");
    msg_q.push_back(CH_NUL);
    add_str("HTTP/1.1\n");
    send_msg();
    // content length saturation and odd leading bytes
    add_str("GET / HTTP/1.1\n");
    foreach (clen_vals[i]) begin
      add_str("Content-Length:");
      if (i == 5) begin
        msg_q.push_back(CH_VT);
        msg_q.push_back(CH_FF);
      end
      add_str(clen_vals[i]);
      msg_q.push_back(CH_CR);
    end
    send_msg();
    // version forms
    foreach (versions[i]) begin
      add_str("G / HTTP/");
      add_str(versions[i]);
      add_crlf();
      send_msg();
    end
    // high bytes in the url
    add_str("GET /");
    msg_q.push_back(8'h80);
    msg_q.push_back(8'hFF);
    add_str(" HTTP/1.1");
    msg_q.push_back(CH_CR);
    send_msg();
  endtask

  task automatic test_random_traffic();
    int first;
    int n;
    first = sent_bytes;
    while (sent_bytes - first < RANDOM_BYTES) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: begin
          msg_q = {};
          rand_text($urandom_range(1, 24), 0, 255);
        end
        1: begin
          build_request();
          n = $urandom_range(1, msg_q.size());
          while (msg_q.size() > n) void'(msg_q.pop_back());
        end
        2: begin
          build_request();
          msg_q.insert($urandom_range(0, msg_q.size() - 1), CH_NUL);
        end
        3: begin
          build_request();
          msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        default: build_request();
      endcase
      send_msg();
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
  endtask

  // back-to-back traffic at full rate on both sides
  task automatic test_no_idle_stream();
    idle_on = 1'b0;
    repeat (8) begin
      build_request();
      send_msg();
    end
  endtask

  initial begin
    parser_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    wait_drained();
    test_random_traffic();
    test_no_idle_stream();
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
